>>> design/cpu8080_pkg.sv
// package for the 8080 instruction step block
// holds payload structs, flag masks, implemented-opcode table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cpu8080_pkg;

  localparam int MemAddrBitsDef = 16;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_PORT = 2'd1;
  localparam logic [1:0] OP_EXEC = 2'd2;

  localparam logic [7:0] FL_S  = 8'h80;
  localparam logic [7:0] FL_Z  = 8'h40;
  localparam logic [7:0] FL_AC = 8'h10;
  localparam logic [7:0] FL_P  = 8'h04;
  localparam logic [7:0] FL_CY = 8'h01;
  localparam logic [7:0] FL_ALL = 8'hD5;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] load_addr;
    logic [7:0]  load_data;
    logic [7:0]  port_sel;
  } step_in_t;

  typedef struct packed {
    logic [4:0]  cycles;
    logic        bad_opcode;
    logic [15:0] prog_counter;
    logic [7:0]  accum;
    logic [7:0]  status_byte;
    logic        out_valid;
    logic [7:0]  out_port;
    logic [7:0]  out_data;
  } step_out_t;

  function automatic logic op_listed(input logic [7:0] ir);
    logic [15:0] row;
    begin
      case (ir[7:4])
        4'h0: row = 16'hF6FF;
        4'h1: row = 16'hDE7E;
        4'h2: row = 16'hDEFE;
        4'h3: row = 16'h74F6;
        4'h4: row = 16'hC1DF;
        4'h5: row = 16'hC0C0;
        4'h6: row = 16'h83F2;
        4'h7: row = 16'h7F8F;
        4'h8: row = 16'h046F;
        4'h9: row = 16'h0080;
        4'hA: row = 16'h81C3;
        4'hB: row = 16'h5151;
        4'hC: row = 16'h377F;
        4'hD: row = 16'h4D7F;
        4'hE: row = 16'h0A6A;
        default: row = 16'h4C62;
      endcase
      op_listed = row[ir[3:0]];
    end
  endfunction

  function automatic logic [7:0] szp(input logic [7:0] v);
    szp = (v[7] ? FL_S : 8'h00) | ((v == 8'h00) ? FL_Z : 8'h00) | (^v ? 8'h00 : FL_P);
  endfunction

endpackage
`default_nettype wire

>>> design/cpu8080_instruction_step.sv
// 8080 instruction step: one beat in, one result beat out
// a beat steps through states with one single-port memory access per cycle
// (fetch, immediates, operand, stack bytes) plus decode and finish states
// a new beat is taken only after the result beat leaves the output register
// reset (rst_n, synchronous): registers, flags, sp, pc, input ports zero; memory not cleared
`timescale 1ns / 1ps
`default_nettype none
module cpu8080_instruction_step
  import cpu8080_pkg::*;
#(
  parameter int MEM_ADDR_BITS = MemAddrBitsDef
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire step_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output step_out_t      out_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_DEC = 4'd2;
  localparam logic [3:0] S_IMM1 = 4'd3;
  localparam logic [3:0] S_IMM2 = 4'd4;
  localparam logic [3:0] S_EXEC = 4'd5;
  localparam logic [3:0] S_MEM1 = 4'd6;
  localparam logic [3:0] S_MEM2 = 4'd7;
  localparam logic [3:0] S_MEM3 = 4'd8;
  localparam logic [3:0] S_MEM4 = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [7:0] mem [0:(1 << MEM_ADDR_BITS) - 1];
  logic [7:0] ports [0:255];
  logic [7:0] port_q;

  logic [3:0]  state_r, state_nxt;
  logic [7:0]  rb_r, rb_nxt, rc_r, rc_nxt, rd_r, rd_nxt, re_r, re_nxt;
  logic [7:0]  rh_r, rh_nxt, rl_r, rl_nxt, ra_r, ra_nxt, fl_r, fl_nxt;
  logic [15:0] sp_r, sp_nxt, pc_r, pc_nxt;
  logic        ie_r, ie_nxt;
  logic [7:0]  ir_r, ir_nxt, lo_r, lo_nxt, hi_r, hi_nxt, tmp_r, tmp_nxt;
  logic [15:0] w_r, w_nxt;
  logic [4:0]  cyc_r, cyc_nxt;
  logic        bad_r, bad_nxt, ov_r, ov_nxt;
  logic [7:0]  op_r, op_nxt;
  logic        ovl_r, ovl_nxt;
  step_out_t   res_r, res_nxt;

  // single memory port
  logic        mwe;
  logic [15:0] maddr;
  logic [7:0]  mwd, mq;
  logic        pwe;
  logic [7:0]  paddr, pwd;

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr[MEM_ADDR_BITS-1:0]] <= mwd;
    mq <= mem[maddr[MEM_ADDR_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pwe) ports[paddr] <= pwd;
    port_q <= ports[paddr];
  end

  // input ports need a clear; done as a sweep after reset
  logic [8:0] clr_r, clr_nxt;
  logic       clr_busy;
  assign clr_busy = ~clr_r[8];

  logic [2:0] d, s;
  logic [1:0] rp;
  assign d = ir_r[5:3];
  assign s = ir_r[2:0];
  assign rp = ir_r[5:4];

  function automatic logic [7:0] rget(input logic [2:0] c, input logic [7:0] b_, c_, d_,
                                      e_, h_, l_, a_, m_);
    case (c)
      3'd0: rget = b_;
      3'd1: rget = c_;
      3'd2: rget = d_;
      3'd3: rget = e_;
      3'd4: rget = h_;
      3'd5: rget = l_;
      3'd6: rget = m_;
      default: rget = a_;
    endcase
  endfunction

  logic [15:0] hl, pair, imm;
  logic        cond;
  logic [7:0]  fmask;
  assign hl = {rh_r, rl_r};
  assign imm = {hi_r, lo_r};
  always_comb begin
    case (rp)
      2'd0: pair = {rb_r, rc_r};
      2'd1: pair = {rd_r, re_r};
      2'd2: pair = hl;
      default: pair = sp_r;
    endcase
    case (d[2:1])
      2'd0: fmask = FL_Z;
      2'd1: fmask = FL_CY;
      2'd2: fmask = FL_P;
      default: fmask = FL_S;
    endcase
    cond = ((fl_r & fmask) != 8'h00) == d[0];
  end

  // shared alu
  logic [2:0] ak;
  logic [7:0] aa, ab, ar, aflag;
  logic [8:0] sum9;
  logic [4:0] sum5;
  logic       cin;
  always_comb begin
    cin = (ak == 3'd1 || ak == 3'd3) ? fl_r[0] : 1'b0;
    sum9 = '0; sum5 = '0;
    aflag = fl_r;
    ar = 8'h00;
    case (ak)
      3'd0, 3'd1: begin
        sum9 = {1'b0, aa} + {1'b0, ab} + {8'h00, cin};
        sum5 = {1'b0, aa[3:0]} + {1'b0, ab[3:0]} + {4'h0, cin};
        ar = sum9[7:0];
        aflag = szp(ar) | (sum5[4] ? FL_AC : 8'h00) | (sum9[8] ? FL_CY : 8'h00);
      end
      3'd2, 3'd3, 3'd7: begin
        sum9 = {1'b0, aa} + {1'b0, ~ab} + {8'h00, ~cin};
        sum5 = {1'b0, aa[3:0]} + {1'b0, ~ab[3:0]} + {4'h0, ~cin};
        ar = sum9[7:0];
        aflag = szp(ar) | (sum5[4] ? FL_AC : 8'h00) | (sum9[8] ? 8'h00 : FL_CY);
      end
      3'd4: begin
        ar = aa & ab;
        aflag = szp(ar) | (((aa | ab) & 8'h08) != 0 ? FL_AC : 8'h00);
      end
      3'd5: begin ar = aa ^ ab; aflag = szp(ar); end
      default: begin ar = aa | ab; aflag = szp(ar); end
    endcase
  end

  logic [7:0] src;
  logic [16:0] dad;
  logic [3:0] dlo, dhi;
  logic [7:0] dcorr;
  logic       dcy;
  logic [4:0] dac;
  logic [7:0] tv;

  always_comb begin
    state_nxt = state_r;
    {rb_nxt, rc_nxt, rd_nxt, re_nxt, rh_nxt, rl_nxt, ra_nxt, fl_nxt} =
      {rb_r, rc_r, rd_r, re_r, rh_r, rl_r, ra_r, fl_r};
    sp_nxt = sp_r; pc_nxt = pc_r; ie_nxt = ie_r;
    ir_nxt = ir_r; lo_nxt = lo_r; hi_nxt = hi_r; tmp_nxt = tmp_r; w_nxt = w_r;
    cyc_nxt = cyc_r; bad_nxt = bad_r; ov_nxt = ov_r; op_nxt = op_r;
    ovl_nxt = ovl_r; res_nxt = res_r;
    clr_nxt = clr_r;
    mwe = 1'b0; maddr = pc_r; mwd = 8'h00;
    pwe = 1'b0; paddr = in_data.port_sel; pwd = in_data.load_data;
    ak = d; aa = ra_r; ab = mq;
    src = rget(s, rb_r, rc_r, rd_r, re_r, rh_r, rl_r, ra_r, mq);
    dad = {1'b0, hl} + {1'b0, pair};
    dlo = ra_r[3:0]; dhi = ra_r[7:4];
    dcorr = 8'h00; dcy = fl_r[0]; dac = '0; tv = 8'h00;
    in_ready = 1'b0;

    if (clr_busy) begin
      pwe = 1'b1; paddr = clr_r[7:0]; pwd = 8'h00;
      clr_nxt = clr_r + 9'd1;
    end

    case (state_r)
      S_IDLE: begin
        in_ready = ~clr_busy && ~ovl_r;
        if (in_valid && in_ready) begin
          cyc_nxt = '0; bad_nxt = 1'b0; ov_nxt = 1'b0; op_nxt = 8'h00;
          tmp_nxt = 8'h00;
          case (in_data.op)
            OP_LOAD: begin
              mwe = 1'b1; maddr = in_data.load_addr; mwd = in_data.load_data;
              state_nxt = S_DONE;
            end
            OP_PORT: begin
              pwe = 1'b1; state_nxt = S_DONE;
            end
            OP_EXEC: begin
              maddr = pc_r; pc_nxt = pc_r + 16'd1; state_nxt = S_DEC;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_DEC: begin
        ir_nxt = mq;
        state_nxt = S_EXEC;
        if (!op_listed(mq)) begin
          bad_nxt = 1'b1; state_nxt = S_DONE;
        end else if (
            (mq[7:6] == 2'b11 && (mq[2:0] == 3'd6 || mq[2:0] == 3'd2 || mq[2:0] == 3'd4 ||
                                  mq == 8'hCD || mq == 8'hC3 || mq == 8'hD3 || mq == 8'hDB))
         || (mq[7:6] == 2'b00 && (mq[2:0] == 3'd6 || mq[3:0] == 4'h1 || mq == 8'h22 ||
                                  mq == 8'h2A || mq == 8'h32 || mq == 8'h3A))) begin
          maddr = pc_r; pc_nxt = pc_r + 16'd1; state_nxt = S_IMM1;
        end else begin
          // operand fetch for register-indirect sources
          maddr = hl;
          if (mq[7:6] == 2'b00 && (mq == 8'h0A || mq == 8'h1A)) begin
            maddr = (mq[4]) ? {rd_r, re_r} : {rb_r, rc_r};
          end else if (mq[7:6] == 2'b11) begin
            maddr = sp_r;
          end
        end
      end
      S_IMM1: begin
        lo_nxt = mq;
        if ((ir_r[7:6] == 2'b11 && (s == 3'd6 || ir_r == 8'hD3 || ir_r == 8'hDB))
            || (ir_r[7:6] == 2'b00 && s == 3'd6)) begin
          state_nxt = S_EXEC;
          paddr = mq;
          maddr = hl;
        end else begin
          maddr = pc_r; pc_nxt = pc_r + 16'd1; state_nxt = S_IMM2;
        end
      end
      S_IMM2: begin
        hi_nxt = mq;
        maddr = {mq, lo_r};
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        if (ir_r[7:6] == 2'b01) begin
          cyc_nxt = (d == 3'd6 || s == 3'd6) ? 5'd7 : 5'd5;
          case (d)
            3'd0: rb_nxt = src;
            3'd1: rc_nxt = src;
            3'd2: rd_nxt = src;
            3'd3: re_nxt = src;
            3'd4: rh_nxt = src;
            3'd5: rl_nxt = src;
            3'd6: begin mwe = 1'b1; maddr = hl; mwd = src; end
            default: ra_nxt = src;
          endcase
        end else if (ir_r[7:6] == 2'b10) begin
          ab = src;
          cyc_nxt = (s == 3'd6) ? 5'd7 : 5'd4;
          fl_nxt = aflag;
          if (d != 3'd7) ra_nxt = ar;
        end else if (ir_r[7:6] == 2'b11 && s == 3'd6) begin
          ab = lo_r; cyc_nxt = 5'd7; fl_nxt = aflag;
          if (d != 3'd7) ra_nxt = ar;
        end else if (ir_r[7:6] == 2'b00) begin
          case (s)
            3'd4, 3'd5, 3'd6: begin
              tv = rget(d, rb_r, rc_r, rd_r, re_r, rh_r, rl_r, ra_r, mq);
              if (s == 3'd4) begin
                tv = tv + 8'd1;
                fl_nxt = (fl_r & FL_CY) | szp(tv) | ((tv[3:0] == 4'h0) ? FL_AC : 8'h00);
                cyc_nxt = (d == 3'd6) ? 5'd10 : 5'd5;
              end else if (s == 3'd5) begin
                tv = tv - 8'd1;
                fl_nxt = (fl_r & FL_CY) | szp(tv) | ((tv[3:0] != 4'hF) ? FL_AC : 8'h00);
                cyc_nxt = (d == 3'd6) ? 5'd10 : 5'd5;
              end else begin
                tv = lo_r;
                cyc_nxt = (d == 3'd6) ? 5'd10 : 5'd7;
              end
              case (d)
                3'd0: rb_nxt = tv;
                3'd1: rc_nxt = tv;
                3'd2: rd_nxt = tv;
                3'd3: re_nxt = tv;
                3'd4: rh_nxt = tv;
                3'd5: rl_nxt = tv;
                3'd6: begin mwe = 1'b1; maddr = hl; mwd = tv; end
                default: ra_nxt = tv;
              endcase
            end
            default: begin
              cyc_nxt = 5'd4;
              case (ir_r[3:0])
                4'h1, 4'h3, 4'hB: begin
                  w_nxt = (ir_r[3:0] == 4'h1) ? imm :
                          (ir_r[3:0] == 4'h3) ? pair + 16'd1 : pair - 16'd1;
                  cyc_nxt = (ir_r[3:0] == 4'h1) ? 5'd10 : 5'd5;
                  case (rp)
                    2'd0: {rb_nxt, rc_nxt} = w_nxt;
                    2'd1: {rd_nxt, re_nxt} = w_nxt;
                    2'd2: {rh_nxt, rl_nxt} = w_nxt;
                    default: sp_nxt = w_nxt;
                  endcase
                end
                4'h9: begin
                  {rh_nxt, rl_nxt} = dad[15:0];
                  fl_nxt = dad[16] ? (fl_r | FL_CY) : (fl_r & ~FL_CY & FL_ALL);
                  cyc_nxt = 5'd10;
                end
                default: begin
                  case (ir_r)
                    8'h02, 8'h12: begin
                      mwe = 1'b1; maddr = pair; mwd = ra_r; cyc_nxt = 5'd7;
                    end
                    8'h0A, 8'h1A: begin ra_nxt = mq; cyc_nxt = 5'd7; end
                    8'h22: begin
                      mwe = 1'b1; maddr = imm + 16'd1; mwd = rh_r; cyc_nxt = 5'd16;
                      state_nxt = S_MEM1;
                    end
                    8'h2A: begin
                      rl_nxt = mq; maddr = imm + 16'd1; cyc_nxt = 5'd16;
                      state_nxt = S_MEM1;
                    end
                    8'h32: begin
                      mwe = 1'b1; maddr = imm; mwd = ra_r; cyc_nxt = 5'd13;
                    end
                    8'h3A: begin ra_nxt = mq; cyc_nxt = 5'd13; end
                    8'h07: begin
                      ra_nxt = {ra_r[6:0], ra_r[7]};
                      fl_nxt = ra_r[7] ? (fl_r | FL_CY) : (fl_r & ~FL_CY);
                    end
                    8'h0F: begin
                      ra_nxt = {ra_r[0], ra_r[7:1]};
                      fl_nxt = ra_r[0] ? (fl_r | FL_CY) : (fl_r & ~FL_CY);
                    end
                    8'h1F: begin
                      ra_nxt = {fl_r[0], ra_r[7:1]};
                      fl_nxt = ra_r[0] ? (fl_r | FL_CY) : (fl_r & ~FL_CY);
                    end
                    8'h27: begin
                      if (fl_r[4] || dlo > 4'd9) dcorr = 8'h06;
                      if (fl_r[0] || dhi > 4'd9 || (dhi >= 4'd9 && dlo > 4'd9)) begin
                        dcorr = dcorr | 8'h60; dcy = 1'b1;
                      end
                      dac = {1'b0, dlo} + {1'b0, dcorr[3:0]};
                      tv = ra_r + dcorr;
                      ra_nxt = tv;
                      fl_nxt = szp(tv) | (dac[4] ? FL_AC : 8'h00) | (dcy ? FL_CY : 8'h00);
                    end
                    8'h2F: ra_nxt = ~ra_r;
                    8'h37: fl_nxt = fl_r | FL_CY;
                    default: ;
                  endcase
                end
              endcase
            end
          endcase
        end else begin
          // c0-ff group, mq holds byte at sp where read
          case (s)
            3'd0: begin
              if (cond) begin
                lo_nxt = mq; maddr = sp_r + 16'd1; cyc_nxt = 5'd11;
                state_nxt = S_MEM1;
              end else cyc_nxt = 5'd5;
            end
            3'd2: begin
              cyc_nxt = 5'd10;
              if (cond) pc_nxt = imm;
            end
            3'd4, 3'd5: begin
              if (s == 3'd4 && !cond) cyc_nxt = 5'd11;
              else begin
                cyc_nxt = (s == 3'd5 && !ir_r[3]) ? 5'd11 : 5'd17;
                if (s == 3'd5 && !ir_r[3])
                  w_nxt = (rp == 2'd3) ? {ra_r, fl_r | 8'h02} : pair;
                else begin
                  w_nxt = pc_r; pc_nxt = imm;
                end
                mwe = 1'b1; maddr = sp_r - 16'd1; mwd = w_nxt[15:8];
                state_nxt = S_MEM3;
              end
            end
            3'd1: begin
              if (ir_r == 8'hE9) begin
                pc_nxt = hl; cyc_nxt = 5'd5;
              end else begin
                lo_nxt = mq; maddr = sp_r + 16'd1;
                cyc_nxt = 5'd10; state_nxt = S_MEM1;
              end
            end
            default: begin
              cyc_nxt = 5'd4;
              case (ir_r)
                8'hC3: begin pc_nxt = imm; cyc_nxt = 5'd10; end
                8'hD3: begin
                  cyc_nxt = 5'd10;
                  if (lo_r != 8'd2 && lo_r != 8'd4) begin
                    pwe = 1'b1; paddr = lo_r; pwd = ra_r;
                    ov_nxt = 1'b1; op_nxt = lo_r; tmp_nxt = ra_r;
                  end
                end
                8'hDB: begin
                  cyc_nxt = 5'd10;
                  if (lo_r != 8'd3) ra_nxt = port_q;
                end
                8'hE3: begin
                  lo_nxt = mq; maddr = sp_r + 16'd1; cyc_nxt = 5'd18;
                  state_nxt = S_MEM1;
                end
                8'hEB: begin
                  {rd_nxt, re_nxt} = hl; {rh_nxt, rl_nxt} = {rd_r, re_r};
                end
                default: ie_nxt = 1'b1;
              endcase
            end
          endcase
        end
      end
      S_MEM1: begin
        state_nxt = S_DONE;
        if (ir_r == 8'h22) begin
          mwe = 1'b1; maddr = imm; mwd = rl_r;
        end else if (ir_r == 8'h2A) begin
          rh_nxt = mq;
        end else if (ir_r == 8'hE3) begin
          w_nxt = {mq, lo_r};
          mwe = 1'b1; maddr = sp_r + 16'd1; mwd = rh_r;
          state_nxt = S_MEM2;
        end else begin
          sp_nxt = sp_r + 16'd2;
          if (s == 3'd1 && !ir_r[3]) begin
            case (rp)
              2'd0: {rb_nxt, rc_nxt} = {mq, lo_r};
              2'd1: {rd_nxt, re_nxt} = {mq, lo_r};
              2'd2: {rh_nxt, rl_nxt} = {mq, lo_r};
              default: begin ra_nxt = mq; fl_nxt = lo_r & FL_ALL; end
            endcase
          end else pc_nxt = {mq, lo_r};
        end
      end
      S_MEM2: begin
        mwe = 1'b1; maddr = sp_r; mwd = rl_r;
        {rh_nxt, rl_nxt} = w_r;
        state_nxt = S_DONE;
      end
      S_MEM3: begin
        mwe = 1'b1; maddr = sp_r - 16'd2; mwd = w_r[7:0];
        sp_nxt = sp_r - 16'd2;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_nxt.cycles = cyc_r;
        res_nxt.bad_opcode = bad_r;
        res_nxt.prog_counter = pc_r;
        res_nxt.accum = ra_r;
        res_nxt.status_byte = (fl_r & FL_ALL) | 8'h02;
        res_nxt.out_valid = ov_r;
        res_nxt.out_port = op_r;
        res_nxt.out_data = tmp_r;
        ovl_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (ovl_r && out_ready) ovl_nxt = (state_r == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      {rb_r, rc_r, rd_r, re_r, rh_r, rl_r, ra_r, fl_r} <= '0;
      sp_r <= '0; pc_r <= '0; ie_r <= 1'b0;
      ovl_r <= 1'b0; clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      {rb_r, rc_r, rd_r, re_r, rh_r, rl_r, ra_r, fl_r} <=
        {rb_nxt, rc_nxt, rd_nxt, re_nxt, rh_nxt, rl_nxt, ra_nxt, fl_nxt};
      sp_r <= sp_nxt; pc_r <= pc_nxt; ie_r <= ie_nxt;
      ovl_r <= ovl_nxt; clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ir_r <= ir_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; tmp_r <= tmp_nxt; w_r <= w_nxt;
    cyc_r <= cyc_nxt; bad_r <= bad_nxt; ov_r <= ov_nxt; op_r <= op_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = ovl_r;
  assign out_data = res_r;

endmodule
`default_nettype wire

>>> verif/testbench.sv
// testbench for cpu8080_instruction_step: directed and random instruction beats
// checked field by field against an in-bench 8080 predictor; needs cpu8080_pkg
`timescale 1ns / 1ps
module testbench;
  import cpu8080_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  step_in_t  in_beat;
  logic      out_valid;
  logic      out_ready;
  step_out_t out_beat;

  cpu8080_instruction_step u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_beat),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_beat)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // predicted cpu state
  bit [7:0]  mem_img [0:65535];
  bit        mem_seen [0:65535];
  bit [7:0]  port_img [0:255];
  bit [7:0]  gpr [0:6];   // B C D E H L A
  bit [15:0] sp_q, pc_q;
  bit [7:0]  flags_q;

  step_out_t expected_steps [$];
  int        errors;
  bit        stim_done;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic void wr8(bit [15:0] a, bit [7:0] v);
    mem_img[a] = v;
    mem_seen[a] = 1'b1;
  endfunction

  function automatic bit [7:0] fetch8();
    bit [7:0] v;
    v = mem_img[pc_q];
    pc_q = pc_q + 16'd1;
    return v;
  endfunction

  function automatic bit [15:0] fetch16();
    bit [7:0] lo;
    lo = fetch8();
    return {fetch8(), lo};
  endfunction

  function automatic void put_flag(bit [7:0] m, bit on);
    flags_q = on ? (flags_q | m) : (flags_q & ~m & FL_ALL);
  endfunction

  function automatic void set_szp(bit [7:0] v);
    put_flag(FL_S, v[7]);
    put_flag(FL_Z, v == 8'h00);
    put_flag(FL_P, ~^v);
  endfunction

  function automatic bit [15:0] hl_pair();
    return {gpr[4], gpr[5]};
  endfunction

  function automatic bit [7:0] get_r(bit [2:0] c);
    if (c == 3'd6) return mem_img[hl_pair()];
    return gpr[c == 3'd7 ? 6 : c];
  endfunction

  function automatic void set_r(bit [2:0] c, bit [7:0] v);
    if (c == 3'd6) wr8(hl_pair(), v);
    else gpr[c == 3'd7 ? 6 : c] = v;
  endfunction

  function automatic bit [15:0] get_pair(bit [1:0] p);
    if (p == 2'd3) return sp_q;
    return {gpr[2*p], gpr[2*p+1]};
  endfunction

  function automatic void set_pair(bit [1:0] p, bit [15:0] v);
    if (p == 2'd3) sp_q = v;
    else begin
      gpr[2*p] = v[15:8];
      gpr[2*p+1] = v[7:0];
    end
  endfunction

  function automatic void push16(bit [15:0] v);
    wr8(sp_q - 16'd1, v[15:8]);
    wr8(sp_q - 16'd2, v[7:0]);
    sp_q = sp_q - 16'd2;
  endfunction

  function automatic bit [15:0] pop16();
    bit [15:0] v;
    v = {mem_img[sp_q + 16'd1], mem_img[sp_q]};
    sp_q = sp_q + 16'd2;
    return v;
  endfunction

  function automatic bit cond_met(bit [2:0] c);
    bit [7:0] m;
    case (c[2:1])
      2'd0: m = FL_Z;
      2'd1: m = FL_CY;
      2'd2: m = FL_P;
      default: m = FL_S;
    endcase
    return c[0] ? ((flags_q & m) != 0) : ((flags_q & m) == 0);
  endfunction

  // 0 add, 1 adc, 2 sub, 3 sbb, 4 ana, 5 xra, 6 ora, 7 cmp
  function automatic void alu_op(bit [2:0] k, bit [7:0] b);
    int unsigned a, c, r, nb;
    a = gpr[6];
    c = (k == 3'd1 || k == 3'd3) ? flags_q[0] : 0;
    if (k <= 3'd1) begin
      r = a + b + c;
      put_flag(FL_AC, (a & 15) + (b & 15) + c > 15);
      put_flag(FL_CY, r > 255);
    end else if (k == 3'd2 || k == 3'd3 || k == 3'd7) begin
      nb = ~b & 8'hFF;
      r = a + nb + 1 - c;
      put_flag(FL_AC, (a & 15) + (nb & 15) + 1 - c > 15);
      put_flag(FL_CY, r <= 255);
    end else begin
      r = (k == 3'd4) ? (a & b) : (k == 3'd5) ? (a ^ b) : (a | b);
      put_flag(FL_AC, k == 3'd4 && ((a | b) & 8) != 0);
      put_flag(FL_CY, 1'b0);
    end
    set_szp(r[7:0]);
    if (k != 3'd7) gpr[6] = r[7:0];
  endfunction

  function automatic void decimal_adjust();
    bit [7:0] a, corr;
    bit [3:0] lo, hi;
    bit cy;
    a = gpr[6]; lo = a[3:0]; hi = a[7:4]; corr = 8'h00;
    cy = flags_q[0];
    if ((flags_q & FL_AC) != 0 || lo > 9) corr = 8'h06;
    if (cy || hi > 9 || (hi >= 9 && lo > 9)) begin
      corr |= 8'h60;
      cy = 1'b1;
    end
    put_flag(FL_AC, {1'b0, lo} + {1'b0, corr[3:0]} > 5'd15);
    put_flag(FL_CY, cy);
    a = a + corr;
    gpr[6] = a;
    set_szp(a);
  endfunction

  function automatic bit [4:0] run_instr(output bit ov, output bit [7:0] oport,
                                         output bit [7:0] odat);
    bit [7:0] ir, a, v8;
    bit [2:0] d, s;
    bit [1:0] rp;
    bit [15:0] v, t;
    bit [16:0] sum;
    ov = 1'b0; oport = 8'h00; odat = 8'h00;
    ir = fetch8();
    d = ir[5:3]; s = ir[2:0]; rp = ir[5:4]; a = gpr[6];
    if (!op_listed(ir)) return 5'd0;
    if (ir >= 8'h40 && ir < 8'h80) begin
      set_r(d, get_r(s));
      return (d == 3'd6 || s == 3'd6) ? 5'd7 : 5'd5;
    end
    if (ir >= 8'h80 && ir < 8'hC0) begin
      alu_op(d, get_r(s));
      return s == 3'd6 ? 5'd7 : 5'd4;
    end
    if (ir >= 8'hC0 && s == 3'd6) begin
      alu_op(d, fetch8());
      return 5'd7;
    end
    if (ir < 8'h40) begin
      case (s)
        3'd4: begin
          v8 = get_r(d) + 8'd1; set_r(d, v8); set_szp(v8);
          put_flag(FL_AC, v8[3:0] == 4'h0);
          return d == 3'd6 ? 5'd10 : 5'd5;
        end
        3'd5: begin
          v8 = get_r(d) - 8'd1; set_r(d, v8); set_szp(v8);
          put_flag(FL_AC, v8[3:0] != 4'hF);
          return d == 3'd6 ? 5'd10 : 5'd5;
        end
        3'd6: begin
          v8 = fetch8(); set_r(d, v8);
          return d == 3'd6 ? 5'd10 : 5'd7;
        end
        default: ;
      endcase
      case (ir[3:0])
        4'h1: begin set_pair(rp, fetch16()); return 5'd10; end
        4'h3: begin set_pair(rp, get_pair(rp) + 16'd1); return 5'd5; end
        4'hB: begin set_pair(rp, get_pair(rp) - 16'd1); return 5'd5; end
        4'h9: begin
          sum = hl_pair() + get_pair(rp);
          put_flag(FL_CY, sum[16]);
          set_pair(2'd2, sum[15:0]);
          return 5'd10;
        end
        default: ;
      endcase
      case (ir)
        8'h02, 8'h12: begin wr8(get_pair(rp), a); return 5'd7; end
        8'h0A, 8'h1A: begin gpr[6] = mem_img[get_pair(rp)]; return 5'd7; end
        8'h22: begin
          v = fetch16(); wr8(v + 16'd1, gpr[4]); wr8(v, gpr[5]);
          return 5'd16;
        end
        8'h2A: begin
          v = fetch16(); gpr[4] = mem_img[v + 16'd1]; gpr[5] = mem_img[v];
          return 5'd16;
        end
        8'h32: begin wr8(fetch16(), a); return 5'd13; end
        8'h3A: begin gpr[6] = mem_img[fetch16()]; return 5'd13; end
        8'h07: begin gpr[6] = {a[6:0], a[7]}; put_flag(FL_CY, a[7]); return 5'd4; end
        8'h0F: begin gpr[6] = {a[0], a[7:1]}; put_flag(FL_CY, a[0]); return 5'd4; end
        8'h1F: begin
          gpr[6] = {flags_q[0], a[7:1]}; put_flag(FL_CY, a[0]);
          return 5'd4;
        end
        8'h27: begin decimal_adjust(); return 5'd4; end
        8'h2F: begin gpr[6] = ~a; return 5'd4; end
        8'h37: begin put_flag(FL_CY, 1'b1); return 5'd4; end
        default: return 5'd4;
      endcase
    end
    case (s)
      3'd0: begin
        if (cond_met(d)) begin pc_q = pop16(); return 5'd11; end
        return 5'd5;
      end
      3'd2: begin
        v = fetch16();
        if (cond_met(d)) pc_q = v;
        return 5'd10;
      end
      3'd4: begin
        v = fetch16();
        if (cond_met(d)) begin push16(pc_q); pc_q = v; return 5'd17; end
        return 5'd11;
      end
      3'd1: begin
        if (!ir[3]) begin
          v = pop16();
          if (rp == 2'd3) begin
            gpr[6] = v[15:8];
            flags_q = v[7:0] & FL_ALL;
          end else set_pair(rp, v);
          return 5'd10;
        end
        if (ir == 8'hC9) begin pc_q = pop16(); return 5'd10; end
        pc_q = hl_pair();
        return 5'd5;
      end
      3'd5: begin
        if (!ir[3]) begin
          push16(rp == 2'd3 ? {a, flags_q | 8'h02} : get_pair(rp));
          return 5'd11;
        end
        v = fetch16(); push16(pc_q); pc_q = v;
        return 5'd17;
      end
      default: begin
        case (ir)
          8'hC3: begin pc_q = fetch16(); return 5'd10; end
          8'hD3: begin
            v8 = fetch8();
            if (v8 != 8'd2 && v8 != 8'd4) begin
              port_img[v8] = a; ov = 1'b1; oport = v8; odat = a;
            end
            return 5'd10;
          end
          8'hDB: begin
            v8 = fetch8();
            if (v8 != 8'd3) gpr[6] = port_img[v8];
            return 5'd10;
          end
          8'hE3: begin
            v = pop16(); push16(hl_pair()); set_pair(2'd2, v);
            return 5'd18;
          end
          8'hEB: begin
            t = get_pair(2'd1); set_pair(2'd1, hl_pair()); set_pair(2'd2, t);
            return 5'd4;
          end
          default: return 5'd4;  // ei
        endcase
      end
    endcase
  endfunction

  function automatic step_out_t predict_step(step_in_t it);
    step_out_t r;
    bit ov;
    bit [7:0] oport, odat;
    r = '0;
    case (it.op)
      OP_LOAD: wr8(it.load_addr, it.load_data);
      OP_PORT: port_img[it.port_sel] = it.load_data;
      OP_EXEC: begin
        r.cycles = run_instr(ov, oport, odat);
        r.bad_opcode = (r.cycles == 5'd0);
        r.out_valid = ov;
        r.out_port = oport;
        r.out_data = odat;
      end
      default: ;
    endcase
    r.prog_counter = pc_q;
    r.accum = gpr[6];
    r.status_byte = (flags_q & FL_ALL) | 8'h02;
    return r;
  endfunction

  function automatic int pick_gap();
    int x;
    x = $urandom_range(99);
    if (x < 65) return 0;
    if (x < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_beat(step_in_t it);
    int gap;
    in_valid <= 1'b1;
    in_beat <= it;
    do @(posedge clk); while (!in_ready);
    expected_steps.push_back(predict_step(it));
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_load(bit [15:0] addr, bit [7:0] data);
    step_in_t it;
    it = '0;
    it.op = OP_LOAD; it.load_addr = addr; it.load_data = data;
    it.port_sel = $urandom;
    send_beat(it);
  endtask

  task automatic send_port(bit [7:0] port, bit [7:0] data);
    step_in_t it;
    it = '0;
    it.op = OP_PORT; it.port_sel = port; it.load_data = data;
    it.load_addr = $urandom;
    send_beat(it);
  endtask

  task automatic make_written(bit [15:0] addr);
    if (!mem_seen[addr]) send_load(addr, $urandom);
  endtask

  // places opcode and maybe operand bytes, fills any byte it will read, executes
  task automatic exec_instr(bit [7:0] ir, bit [7:0] b1, bit [7:0] b2, bit force_imm);
    bit [15:0] p, imm;
    bit [2:0] s, d;
    step_in_t it;
    p = pc_q; s = ir[2:0]; d = ir[5:3];
    send_load(p, ir);
    if (force_imm || !mem_seen[p + 16'd1] || $urandom_range(1)) send_load(p + 16'd1, b1);
    if (force_imm || !mem_seen[p + 16'd2] || $urandom_range(1)) send_load(p + 16'd2, b2);
    imm = {mem_img[p + 16'd2], mem_img[p + 16'd1]};
    if (op_listed(ir)) begin
      if (ir >= 8'h40 && ir < 8'hC0 && s == 3'd6) make_written(hl_pair());
      if (ir < 8'h40 && (s == 3'd4 || s == 3'd5) && d == 3'd6) make_written(hl_pair());
      if (ir == 8'h0A || ir == 8'h1A) make_written(get_pair(ir[5:4]));
      if (ir == 8'h2A) begin make_written(imm); make_written(imm + 16'd1); end
      if (ir == 8'h3A) make_written(imm);
      if (ir >= 8'hC0 && (s == 3'd0 || (s == 3'd1 && !ir[3]) || ir == 8'hC9 ||
                          ir == 8'hE3)) begin
        make_written(sp_q);
        make_written(sp_q + 16'd1);
      end
    end
    it = '0;
    it.op = OP_EXEC; it.load_addr = $urandom; it.load_data = $urandom;
    it.port_sel = $urandom;
    send_beat(it);
  endtask

  task automatic test_directed();
    step_in_t it;
    send_load(16'hFFFF, 8'h00);
    send_load(16'h8000, 8'hFF);
    exec_instr(8'h3E, 8'hFF, 8'h00, 1'b1);   // mvi a
    exec_instr(8'hC6, 8'h01, 8'h00, 1'b1);   // adi: zero, carry, half carry
    exec_instr(8'h27, 8'h00, 8'h00, 1'b1);   // daa
    exec_instr(8'hD6, 8'h9B, 8'h00, 1'b1);   // sui borrow
    exec_instr(8'h27, 8'h00, 8'h00, 1'b1);
    exec_instr(8'hD3, 8'h02, 8'h00, 1'b1);   // out to ignored ports
    exec_instr(8'hD3, 8'h04, 8'h00, 1'b1);
    exec_instr(8'hD3, 8'h55, 8'h00, 1'b1);   // out, then read it back
    exec_instr(8'hAF, 8'h00, 8'h00, 1'b1);
    exec_instr(8'hDB, 8'h55, 8'h00, 1'b1);
    send_port(8'h03, 8'h77);
    exec_instr(8'hDB, 8'h03, 8'h00, 1'b1);   // ignored in port
    send_port(8'hFF, 8'hA5);
    exec_instr(8'hDB, 8'hFF, 8'h00, 1'b1);
    exec_instr(8'h08, 8'h00, 8'h00, 1'b1);   // unlisted opcode
    it = '0; it.op = 2'd3; it.load_addr = 16'hFFFF; it.load_data = 8'hFF;
    it.port_sel = 8'hFF;
    send_beat(it);
    exec_instr(8'h31, 8'h00, 8'h00, 1'b1);   // lxi sp,0: stack wraps
    exec_instr(8'hF5, 8'h00, 8'h00, 1'b1);
    exec_instr(8'hC1, 8'h00, 8'h00, 1'b1);
    exec_instr(8'hCD, 8'h00, 8'hC0, 1'b1);   // call / ret
    exec_instr(8'hC9, 8'h00, 8'h00, 1'b1);
    exec_instr(8'hE3, 8'h00, 8'h00, 1'b1);
  endtask

  task automatic test_random();
    int n, x;
    for (n = 0; n < 400; n++) begin
      x = $urandom_range(99);
      if (x < 6) send_load($urandom, $urandom);
      else if (x < 10) send_port($urandom, $urandom);
      else exec_instr($urandom, $urandom, $urandom, 1'b0);
    end
  endtask

  // result side: random stalls with quiet stretches
  initial begin
    int mode, left;
    out_ready = 1'b0;
    mode = 0; left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(2);
        left = $urandom_range(5, 60);
      end
      left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(3) != 0);
        default: out_ready <= ($urandom_range(9) == 0) ||
                              ($urandom_range(30) == 0 ? 1'b0 : $urandom_range(1));
      endcase
    end
  end

  always @(posedge clk) begin
    step_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_steps.size() == 0) begin
        $display("mismatch: result beat with none expected");
        errors++;
      end else begin
        want = expected_steps.pop_front();
        if (out_beat.cycles != want.cycles)
          report_mismatch("cycles", out_beat.cycles, want.cycles);
        if (out_beat.bad_opcode != want.bad_opcode)
          report_mismatch("bad_opcode", out_beat.bad_opcode, want.bad_opcode);
        if (out_beat.prog_counter != want.prog_counter)
          report_mismatch("prog_counter", out_beat.prog_counter, want.prog_counter);
        if (out_beat.accum != want.accum)
          report_mismatch("accum", out_beat.accum, want.accum);
        if (out_beat.status_byte != want.status_byte)
          report_mismatch("status_byte", out_beat.status_byte, want.status_byte);
        if (out_beat.out_valid != want.out_valid)
          report_mismatch("out_valid", out_beat.out_valid, want.out_valid);
        if (out_beat.out_port != want.out_port)
          report_mismatch("out_port", out_beat.out_port, want.out_port);
        if (out_beat.out_data != want.out_data)
          report_mismatch("out_data", out_beat.out_data, want.out_data);
      end
    end
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    errors = 0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_beat = '0;
    sp_q = '0; pc_q = '0; flags_q = '0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (port_img[i]) port_img[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random();
    in_valid <= 1'b0;
    stim_done = 1'b1;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
